@@ hdl/dcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared types and constants for the directed cycle detector.
// ----------------------------------------------------------------------------
`default_nettype none
package dcd_pkg;
  localparam int unsigned FieldW = 11;
  localparam int unsigned NodeCountReset = 1024;

  typedef enum logic [1:0] {
    MARK_WHITE = 2'd0,
    MARK_GRAY  = 2'd1,
    MARK_BLACK = 2'd2
  } mark_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_HEAD_RD,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_TOP,
    ST_EDGE_RD,
    ST_DEST_CHK,
    ST_RESULT,
    ST_CLEAR
  } state_e;
endpackage
`default_nettype wire

@@ hdl/dcd_edge_if.sv @@
// ----------------------------------------------------------------------------
// dcd_edge_if
// Input edge channel: valid/ready with one edge transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface dcd_edge_if;
  logic              valid;
  logic              ready;
  logic              edge_present;
  logic [10:0]       edge_source;
  logic [10:0]       edge_target;
  logic              last_edge;
  modport source (output valid, edge_present, edge_source, edge_target, last_edge,
                  input ready);
  modport sink (input valid, edge_present, edge_source, edge_target, last_edge,
                output ready);
endinterface
`default_nettype wire

@@ hdl/dcd_result_if.sv @@
// ----------------------------------------------------------------------------
// dcd_result_if
// Result channel: valid/ready with one verdict transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface dcd_result_if;
  logic valid;
  logic ready;
  logic has_cycle;
  logic edges_overflowed;
  logic bad_endpoint_seen;
  modport source (output valid, has_cycle, edges_overflowed, bad_endpoint_seen,
                  input ready);
  modport sink (input valid, has_cycle, edges_overflowed, bad_endpoint_seen,
                output ready);
endinterface
`default_nettype wire

@@ hdl/directed_cycle_detector_top.sv @@
// ----------------------------------------------------------------------------
// directed_cycle_detector_top
// Stores directed edges as per-node adjacency lists and, on the last edge,
// runs an iterative depth-first walk to find a directed cycle.
// ----------------------------------------------------------------------------
// Usage:
//   edge_in carries one edge per transaction. A stored edge takes two steps
//   (head read, then link and head write), so ready drops for one cycle after
//   it; a dropped edge or a bare marker causes no such drop.
//   After a transaction with last_edge set, ready stays low while the walk
//   runs; the walk starts once any edge store has finished. Each start node
//   takes ST_SCAN and ST_SCAN_CHK, each edge followed ST_TOP, ST_EDGE_RD,
//   ST_DEST_CHK, and each pop ST_TOP, ST_EDGE_RD (ST_TOP alone for the pop
//   that empties the stack), as the node and edge memories are single-port.
//   One result transaction appears on result_out in the cycle after the walk
//   ends and stays until taken; no edge is accepted while it waits. After it
//   is taken, a clearing pass over all MAX_NODES slots empties adjacency heads
//   and marks before the next graph is accepted. Reset also starts with this pass.
//   cfg_we_i/cfg_data_i write node_count; write only while idle.
//   Edges with an endpoint outside 1..node_count (capped at MAX_NODES), or
//   arriving with the store full, are dropped and flagged in the result.
// ----------------------------------------------------------------------------
`default_nettype none
module directed_cycle_detector_top
  import dcd_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_data_i,
  dcd_edge_if.sink         edge_in,
  dcd_result_if.source     result_out
);
  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned LW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned CW  = $clog2(MAX_NODES + 1);
  localparam int unsigned VW  = (CW > FieldW) ? CW : FieldW;

  // memories
  logic [LW-1:0]     head_mem [MAX_NODES];
  logic [1:0]        mark_mem [MAX_NODES];
  logic [FieldW-1:0] dest_mem [MAX_EDGES];
  logic [LW-1:0]     link_mem [MAX_EDGES];
  logic [NW-1:0]     stk_node [MAX_NODES];
  logic [LW-1:0]     stk_cur  [MAX_NODES];

  state_e state_q, state_d;
  logic [FieldW-1:0] count_q;
  logic [LW-1:0]     stored_q;
  logic [CW-1:0]     depth_q;
  logic [CW-1:0]     start_q;
  logic [NW-1:0]     clr_q;
  logic              ovf_q, bad_q, cyc_q;
  logic [NW-1:0]     top_node_q;
  logic [LW-1:0]     top_cur_q;
  logic [FieldW-1:0] dest_q;

  // memory read data
  logic [LW-1:0]     head_rd;
  logic [1:0]        mark_rd;
  logic [FieldW-1:0] dest_rd;
  logic [LW-1:0]     link_rd;
  logic [NW-1:0]     stkn_rd;
  logic [LW-1:0]     stkc_rd;

  // memory controls
  logic              n_re, n_we_h, n_we_m;
  logic [NW-1:0]     n_addr;
  logic [LW-1:0]     n_wh;
  logic [1:0]        n_wm;
  logic              e_we;
  logic [EW-1:0]     e_addr;
  logic              s_we_n, s_we_c;
  logic [NW-1:0]     s_waddr, s_raddr;
  logic [NW-1:0]     s_wnode;
  logic [LW-1:0]     s_wcur;

  logic [VW-1:0] eff_count;
  assign eff_count = (VW'(count_q) > VW'(MAX_NODES)) ? VW'(MAX_NODES) : VW'(count_q);

  // edge insert pipeline: head read now, link/head write next cycle
  logic              ins_q;
  logic [NW-1:0]     ins_node_q;
  logic [LW-1:0]     ins_idx_q;
  logic [FieldW-1:0] ins_dst_q;
  logic              last_pend_q;

  logic acc;
  assign edge_in.ready = (state_q == ST_LOAD) && !ins_q && !last_pend_q;
  assign acc = edge_in.valid && edge_in.ready;

  logic src_ok, dst_ok, store_ok;
  assign src_ok = (edge_in.edge_source != '0) && (VW'(edge_in.edge_source) <= eff_count);
  assign dst_ok = (edge_in.edge_target != '0) && (VW'(edge_in.edge_target) <= eff_count);
  assign store_ok = acc && edge_in.edge_present && src_ok && dst_ok
                    && (stored_q < LW'(MAX_EDGES));

  logic [NW-1:0] src_slot;
  assign src_slot = NW'(edge_in.edge_source - 11'd1);

  logic [NW-1:0] dest_slot;
  assign dest_slot = NW'(dest_q - 11'd1);

  always_ff @(posedge clk_i) begin
    if (n_re) begin
      head_rd <= head_mem[n_addr];
      mark_rd <= mark_mem[n_addr];
    end
    if (n_we_h) head_mem[n_addr] <= n_wh;
    if (n_we_m) mark_mem[n_addr] <= n_wm;
  end

  always_ff @(posedge clk_i) begin
    dest_rd <= dest_mem[e_addr];
    link_rd <= link_mem[e_addr];
    if (e_we) begin
      dest_mem[e_addr] <= ins_dst_q;
      link_mem[e_addr] <= head_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    stkn_rd <= stk_node[s_raddr];
    stkc_rd <= stk_cur[s_raddr];
    if (s_we_n) stk_node[s_waddr] <= s_wnode;
    if (s_we_c) stk_cur[s_waddr] <= s_wcur;
  end

  always_comb begin
    state_d = state_q;
    n_re = 1'b0; n_we_h = 1'b0; n_we_m = 1'b0;
    n_addr = '0; n_wh = '0; n_wm = MARK_WHITE;
    e_we = 1'b0; e_addr = EW'(top_cur_q - LW'(1));
    s_we_n = 1'b0; s_we_c = 1'b0;
    s_waddr = NW'(depth_q - CW'(1)); s_raddr = NW'(depth_q - CW'(1));
    s_wnode = top_node_q; s_wcur = link_rd;
    unique case (state_q)
      ST_LOAD: begin
        if (ins_q) begin
          // write link and new head for the edge read last cycle
          e_we = 1'b1; e_addr = EW'(ins_idx_q);
          n_we_h = 1'b1; n_addr = ins_node_q; n_wh = ins_idx_q + LW'(1);
        end else if (store_ok) begin
          n_re = 1'b1; n_addr = src_slot;
        end
        if (last_pend_q && !ins_q) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (start_q > CW'(eff_count)) begin
          state_d = ST_RESULT;
        end else begin
          n_re = 1'b1; n_addr = NW'(start_q - CW'(1));
          state_d = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (mark_rd != MARK_WHITE) begin
          state_d = ST_SCAN;
        end else begin
          n_we_m = 1'b1; n_addr = NW'(start_q - CW'(1)); n_wm = MARK_GRAY;
          s_we_n = 1'b1; s_we_c = 1'b1; s_waddr = '0;
          s_wnode = NW'(start_q - CW'(1)); s_wcur = head_rd;
          state_d = ST_TOP;
        end
      end
      ST_TOP: begin
        // top entry registered in top_*_q
        if (top_cur_q == '0 || top_cur_q > LW'(MAX_EDGES)) begin
          n_we_m = 1'b1; n_addr = top_node_q; n_wm = MARK_BLACK;
          s_raddr = NW'(depth_q - CW'(2));
          state_d = (depth_q == CW'(1)) ? ST_SCAN : ST_EDGE_RD;
        end else begin
          state_d = ST_EDGE_RD;
        end
      end
      ST_EDGE_RD: begin
        // after pop: fetch restored top; after edge read: advance cursor
        if (top_cur_q == '0 || top_cur_q > LW'(MAX_EDGES)) begin
          state_d = ST_TOP;
        end else begin
          s_we_c = 1'b1; s_wcur = link_rd;
          if (dest_rd == '0 || VW'(dest_rd) > VW'(MAX_NODES)) begin
            state_d = ST_TOP;
          end else begin
            n_re = 1'b1; n_addr = NW'(dest_rd - 11'd1);
            state_d = ST_DEST_CHK;
          end
        end
      end
      ST_DEST_CHK: begin
        if (mark_rd == MARK_WHITE) begin
          n_we_m = 1'b1; n_addr = dest_slot; n_wm = MARK_GRAY;
          s_we_n = 1'b1; s_we_c = 1'b1; s_waddr = NW'(depth_q);
          s_wnode = dest_slot; s_wcur = head_rd;
          state_d = ST_TOP;
        end else if (mark_rd == MARK_GRAY) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_TOP;
        end
      end
      ST_RESULT: begin
        if (result_out.ready) state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        n_we_h = 1'b1; n_we_m = 1'b1; n_addr = clr_q;
        if (clr_q == NW'(MAX_NODES - 1)) state_d = ST_LOAD;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      count_q <= FieldW'(NodeCountReset);
      stored_q <= '0; depth_q <= '0; start_q <= CW'(1); clr_q <= '0;
      ovf_q <= 1'b0; bad_q <= 1'b0; cyc_q <= 1'b0;
      ins_q <= 1'b0; last_pend_q <= 1'b0;
      top_node_q <= '0; top_cur_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) count_q <= cfg_data_i;
      ins_q <= store_ok;
      if (state_q == ST_LOAD) begin
        if (acc) begin
          if (edge_in.edge_present && !(src_ok && dst_ok)) bad_q <= 1'b1;
          else if (edge_in.edge_present && stored_q >= LW'(MAX_EDGES)) ovf_q <= 1'b1;
          if (store_ok) begin
            ins_node_q <= src_slot; ins_idx_q <= stored_q;
            ins_dst_q <= edge_in.edge_target; stored_q <= stored_q + LW'(1);
          end
          if (edge_in.last_edge) last_pend_q <= 1'b1;
        end
        if (state_d == ST_SCAN) begin
          last_pend_q <= 1'b0; start_q <= CW'(1); cyc_q <= 1'b0;
        end
      end
      unique case (state_q)
        ST_SCAN_CHK: begin
          if (mark_rd == MARK_WHITE) begin
            depth_q <= CW'(1);
            top_node_q <= NW'(start_q - CW'(1)); top_cur_q <= head_rd;
          end
          start_q <= start_q + CW'(1);
        end
        ST_TOP: begin
          if (top_cur_q == '0 || top_cur_q > LW'(MAX_EDGES)) begin
            depth_q <= depth_q - CW'(1);
          end
        end
        ST_EDGE_RD: begin
          if (top_cur_q == '0 || top_cur_q > LW'(MAX_EDGES)) begin
            top_node_q <= stkn_rd; top_cur_q <= stkc_rd;
          end else begin
            top_cur_q <= link_rd; dest_q <= dest_rd;
          end
        end
        ST_DEST_CHK: begin
          if (mark_rd == MARK_WHITE && depth_q < CW'(MAX_NODES)) begin
            depth_q <= depth_q + CW'(1);
            top_node_q <= dest_slot; top_cur_q <= head_rd;
          end else if (mark_rd == MARK_GRAY) begin
            cyc_q <= 1'b1;
          end
        end
        ST_CLEAR: begin
          clr_q <= (state_d == ST_LOAD) ? '0 : clr_q + NW'(1);
          if (state_d == ST_LOAD) begin
            stored_q <= '0; ovf_q <= 1'b0; bad_q <= 1'b0;
            depth_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign result_out.valid = (state_q == ST_RESULT);
  assign result_out.has_cycle = cyc_q;
  assign result_out.edges_overflowed = ovf_q;
  assign result_out.bad_endpoint_seen = bad_q;
endmodule
`default_nettype wire

@@ hdl/dcd_checker.sv @@
// ----------------------------------------------------------------------------
// dcd_checker
// Port-level checks for the directed cycle detector.
// ----------------------------------------------------------------------------
`default_nettype none
module dcd_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_last_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_cyc_i
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("edge taken during result");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_cyc_i))
    else $error("result dropped");
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("accepted past last edge");
endmodule

bind directed_cycle_detector_top dcd_checker u_dcd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(edge_in.valid), .in_ready_i(edge_in.ready),
  .in_last_i(edge_in.last_edge),
  .out_valid_i(result_out.valid), .out_ready_i(result_out.ready),
  .out_cyc_i(result_out.has_cycle)
);
`default_nettype wire
